@@ design/lfq_pkg.sv @@
package lfq_pkg;

  localparam int unsigned NODES_DEF      = 256;
  localparam int unsigned THREADS_DEF    = 8;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Stream payload layout
  localparam int unsigned TID_BITS      = 3;
  localparam int unsigned PORT_VAL_BITS = 32;
  localparam int unsigned IN_DATA_BITS  = 40;
  localparam int unsigned OUT_DATA_BITS = 48;
  localparam int unsigned SIZE_OUT_BITS = 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } lfq_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_ALLOC,
    ST_ENQ_LINK,
    ST_DEQ_POP,
    ST_RESP
  } lfq_state_e;

  typedef struct packed {
    logic accept;
    logic enq_alloc;
    logic enq_link;
    logic deq_pop;
    logic load_out;
  } lfq_cmd_t;

  typedef struct packed {
    logic in_deq;
    logic enq_ok;
    logic out_free;
  } lfq_sts_t;

endpackage

@@ design/lfq_ctrl.sv @@
module lfq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfq_pkg::lfq_sts_t sts_i,
  output lfq_pkg::lfq_cmd_t cmd_o
);

  lfq_pkg::lfq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_deq ? lfq_pkg::ST_DEQ_POP : lfq_pkg::ST_ENQ_ALLOC;
        end
      end
      lfq_pkg::ST_ENQ_ALLOC: begin
        state_d = sts_i.enq_ok ? lfq_pkg::ST_ENQ_LINK : lfq_pkg::ST_RESP;
      end
      lfq_pkg::ST_ENQ_LINK: state_d = lfq_pkg::ST_RESP;
      lfq_pkg::ST_DEQ_POP:  state_d = lfq_pkg::ST_RESP;
      lfq_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = lfq_pkg::ST_IDLE;
        end
      end
      default: state_d = lfq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lfq_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      lfq_pkg::ST_ENQ_ALLOC: cmd_o.enq_alloc = 1'b1;
      lfq_pkg::ST_ENQ_LINK:  cmd_o.enq_link  = 1'b1;
      lfq_pkg::ST_DEQ_POP:   cmd_o.deq_pop   = 1'b1;
      lfq_pkg::ST_RESP:      cmd_o.load_out  = sts_i.out_free;
      default: ;
    endcase
  end

  // Tail relink only follows a successful allocation
  a_link_after_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfq_pkg::ST_ENQ_LINK |->
      $past(state_q) == lfq_pkg::ST_ENQ_ALLOC && $past(sts_i.enq_ok))
    else $error("tail relink without allocated node");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfq_pkg::ST_RESP && !sts_i.out_free |=> state_q == lfq_pkg::ST_RESP)
    else $error("result left while the output register was full");

endmodule

@@ design/lfq_dp.sv @@
module lfq_dp #(
  parameter int unsigned NODES      = lfq_pkg::NODES_DEF,
  parameter int unsigned THREADS    = lfq_pkg::THREADS_DEF,
  parameter int unsigned VALUE_BITS = lfq_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lfq_pkg::lfq_cmd_t                     cmd_i,
  output lfq_pkg::lfq_sts_t                     sts_o,
  input  logic [lfq_pkg::IN_DATA_BITS-1:0]      in_data_i,
  input  logic                                  in_user_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [lfq_pkg::OUT_DATA_BITS-1:0]     out_data_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = NW + 1;
  localparam int unsigned SW = $clog2(NODES + 1);
  localparam int unsigned TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);
  localparam int unsigned PW = lfq_pkg::PORT_VAL_BITS;

  logic [VALUE_BITS-1:0] value_mem [NODES];
  logic [LW-1:0]         link_mem  [NODES];

  logic [LW-1:0] free_head_q [THREADS];
  logic [SW-1:0] free_size_q [THREADS];
  logic [NW-1:0] head_q, tail_q;
  logic [LW-1:0] fresh_q;
  logic          link0_ok_q;

  logic            op_q;
  logic [TW-1:0]   t_q;
  logic [PW-1:0]   val_q;
  logic [LW-1:0]   link_raw_q;
  logic            rd_zero_null_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [NW-1:0]   node_q;
  logic            res_ok_q, res_rec_q;

  logic                               out_valid_q;
  logic [lfq_pkg::OUT_DATA_BITS-1:0]  out_data_q;

  logic [lfq_pkg::TID_BITS-1:0] tid_mod;
  logic [TW-1:0]   t_in;
  logic            in_deq;
  logic [NW-1:0]   rd_addr;
  logic [LW-1:0]   link_rd;
  logic [LW-1:0]   fh;
  logic            from_free, from_pool, enq_ok;
  logic [NW-1:0]   alloc_node;
  logic            deq_ok;
  logic            lw_en;
  logic [NW-1:0]   lw_addr;
  logic [LW-1:0]   lw_data;
  logic [SW+lfq_pkg::SIZE_OUT_BITS-1:0] size_ext;
  logic [lfq_pkg::SIZE_OUT_BITS-1:0]    size_out;
  logic [PW-1:0]   dv_out;

  assign in_deq = (in_user_i == lfq_pkg::OP_DEQ);

  // Fold an out-of-range thread back into range
  always_comb begin
    tid_mod = in_data_i[lfq_pkg::TID_BITS-1:0];
    for (int k = 0; k < 8; k++) begin
      if (int'(tid_mod) >= int'(THREADS)) begin
        tid_mod = tid_mod - lfq_pkg::TID_BITS'(THREADS);
      end
    end
  end
  assign t_in = TW'(tid_mod);

  assign rd_addr = in_deq ? head_q : free_head_q[t_in][NW-1:0];
  assign link_rd = rd_zero_null_q ? NULL_LINK : link_raw_q;

  assign fh         = free_head_q[t_q];
  assign from_free  = fh < NULL_LINK;
  assign from_pool  = fresh_q < NULL_LINK;
  assign enq_ok     = from_free || from_pool;
  assign alloc_node = from_free ? fh[NW-1:0] : fresh_q[NW-1:0];
  assign deq_ok     = link_rd < NULL_LINK;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = alloc_node;
    lw_data = NULL_LINK;
    if (cmd_i.enq_alloc) begin
      lw_en = enq_ok;
    end else if (cmd_i.enq_link) begin
      lw_en   = 1'b1;
      lw_addr = tail_q;
      lw_data = {1'b0, node_q};
    end else if (cmd_i.deq_pop) begin
      lw_en   = deq_ok;
      lw_addr = head_q;
      lw_data = fh;
    end
  end

  // Node memories
  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (cmd_i.accept) begin
      link_raw_q     <= link_mem[rd_addr];
      rd_zero_null_q <= (rd_addr == '0) && !link0_ok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_alloc && enq_ok) begin
      value_mem[alloc_node] <= VALUE_BITS'(val_q);
    end
    if (cmd_i.deq_pop) begin
      val_rd_q <= value_mem[link_rd[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link0_ok_q <= 1'b0;
    end else if (lw_en && lw_addr == '0) begin
      link0_ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_user_i;
      val_q <= in_data_i[lfq_pkg::TID_BITS +: PW];
    end
    if (cmd_i.enq_alloc) begin
      node_q    <= alloc_node;
      res_ok_q  <= enq_ok;
      res_rec_q <= 1'b0;
    end
    if (cmd_i.deq_pop) begin
      res_ok_q  <= deq_ok;
      res_rec_q <= deq_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q     <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fresh_q <= LW'(1);
      for (int i = 0; i < int'(THREADS); i++) begin
        free_head_q[i] <= NULL_LINK;
        free_size_q[i] <= '0;
      end
    end else begin
      if (cmd_i.accept) begin
        t_q <= t_in;
      end
      if (cmd_i.enq_alloc && enq_ok) begin
        if (from_free) begin
          free_head_q[t_q] <= link_rd;
          if (free_size_q[t_q] != '0) begin
            free_size_q[t_q] <= free_size_q[t_q] - SW'(1);
          end
        end else begin
          fresh_q <= fresh_q + LW'(1);
        end
      end
      if (cmd_i.enq_link) begin
        tail_q <= node_q;
      end
      if (cmd_i.deq_pop && deq_ok) begin
        head_q           <= link_rd[NW-1:0];
        free_head_q[t_q] <= {1'b0, head_q};
        free_size_q[t_q] <= free_size_q[t_q] + SW'(1);
      end
    end
  end

  // Result assembly: saturate the list length for the port
  assign size_ext = {{lfq_pkg::SIZE_OUT_BITS{1'b0}}, free_size_q[t_q]};
  assign size_out = (size_ext > (SW + lfq_pkg::SIZE_OUT_BITS)'(255)) ?
                    lfq_pkg::SIZE_OUT_BITS'(255) : size_ext[lfq_pkg::SIZE_OUT_BITS-1:0];
  assign dv_out   = (res_ok_q && op_q == lfq_pkg::OP_DEQ) ? PW'(val_rd_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {6'd0, size_out, res_rec_q, dv_out, res_ok_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.in_deq   = in_deq;
  assign sts_o.enq_ok   = enq_ok;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Empty free list and null free head go together
  a_free_list_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_size_q[t_q] == '0) == (free_head_q[t_q] >= NULL_LINK))
    else $error("free list count disagrees with its head");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= NULL_LINK && fresh_q != '0)
    else $error("pool pointer out of range");

  a_recycle_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[PW+1] |-> out_data_q[0])
    else $error("recycled node reported on a failed item");

  a_enq_link_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_link |=> tail_q == $past(node_q) && link0_ok_q == 1'b1 || $past(tail_q) != '0)
    else $error("tail relink did not land");

endmodule

@@ design/linked_fifo_with_thread_free_lists.sv @@
// Sequence: an enqueue passes the allocate, relink and response states before
//   its result is registered; a dequeue passes pop and response, and an enqueue
//   that finds no node passes allocate and response. Only one item is in flight;
//   a new one is taken once the last result is loaded into the free output register.
// Reset: asynchronous, active low; clears pointers, counts and the node 0 link
//   flag at once. Node memories are not swept; no start-up delay.
module linked_fifo_with_thread_free_lists #(
  parameter int unsigned NODES      = lfq_pkg::NODES_DEF,
  parameter int unsigned THREADS    = lfq_pkg::THREADS_DEF,
  parameter int unsigned VALUE_BITS = lfq_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] tid, [34:3] value, [39:35] zero
  input  logic [lfq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] op
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] ok, [32:1] deq_value, [33] recycled, [41:34] free_list_size, [47:42] zero
  output logic [lfq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  lfq_pkg::lfq_cmd_t cmd;
  lfq_pkg::lfq_sts_t sts;

  lfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfq_dp #(
    .NODES      (NODES),
    .THREADS    (THREADS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
